// ===== rtl/sha1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned QueueDepth = 4;

  // Request kinds carried in tuser of the input stream.
  localparam logic ReqAppend = 1'b0;
  localparam logic ReqFinish = 1'b1;

  localparam logic [31:0] RoundK0 = 32'h5a827999;
  localparam logic [31:0] RoundK1 = 32'h6ed9eba1;
  localparam logic [31:0] RoundK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RoundK3 = 32'hca62c1d6;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [2:0] LastWord  = 3'd4;

  localparam logic [4:0][31:0] InitChain = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  // One queued request from the front end to the hashing engine.
  typedef struct packed {
    logic        finish;
    logic [7:0]  data;
    logic [31:0] msg_len;
    logic        wrapped;
  } sha1_cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StUpdate,
    StEmit
  } core_state_e;

endpackage

// ===== rtl/sha1_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_front
// Accepts input requests, keeps the message byte count and overflow flag,
// and turns each request into a queue entry.
// ----------------------------------------------------------------------------
module sha1_front
  import sha1_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] data_byte
  input  logic       s_tuser_i,   // [0] req_type
  input  logic       q_full_i,
  output logic       q_push_o,
  output sha1_cmd_t  q_cmd_o
);

  logic [31:0] count_q, count_d;
  logic        wrap_q, wrap_d;
  logic        is_finish;

  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && !q_full_i;
  assign is_finish  = (s_tuser_i == ReqFinish);

  assign q_cmd_o.finish  = is_finish;
  assign q_cmd_o.data    = s_tdata_i;
  assign q_cmd_o.msg_len = count_q;
  assign q_cmd_o.wrapped = wrap_q;

  always_comb begin
    count_d = count_q;
    wrap_d  = wrap_q;
    if (q_push_o) begin
      if (is_finish) begin
        count_d = '0;
        wrap_d  = 1'b0;
      end else begin
        count_d = count_q + 32'd1;
        // The count rolls over to zero on the byte after all ones.
        if (count_q == '1) begin
          wrap_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wrap_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      wrap_q  <= wrap_d;
    end
  end

endmodule

// ===== rtl/sha1_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_queue
// Small first-in first-out buffer of requests between front end and engine.
// ----------------------------------------------------------------------------
module sha1_queue
  import sha1_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sha1_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output sha1_cmd_t cmd_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha1_cmd_t           entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sha1_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_core
// Hashing engine: packs bytes into the block, pads, runs one SHA-1 round
// per cycle and streams out the five digest words.
// ----------------------------------------------------------------------------
module sha1_core
  import sha1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  sha1_cmd_t   q_cmd_i,
  output logic        q_pop_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,  // [31:0] digest_word
  output logic [3:0]  m_tuser_o,  // [2:0] word_index, [3] length_overflow
  output logic        m_tlast_o   // last_word
);

  core_state_e state_q, state_d;

  logic [15:0][31:0] blk_q;
  logic [4:0][31:0]  chain_q;
  logic [31:0]       a_q, b_q, c_q, d_q, e_q;
  logic [5:0]        off_q;
  logic [6:0]        rnd_q;
  logic [31:0]       len_q;
  logic              wrap_q;
  logic              pad_q, first_q, lenph_q;
  logic [2:0]        emit_idx_q;
  logic              out_valid_q, out_last_q, out_ovf_q;
  logic [31:0]       out_word_q;
  logic [2:0]        out_idx_q;

  logic        put_en;
  logic [7:0]  put_val, pad_val, len_byte;
  logic        blk_full;
  logic        emit_load;
  logic [31:0] f_k, t_sum, w_new;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (q_pop_o) begin
          if (q_cmd_i.finish) begin
            state_d = StPad;
          end else if (blk_full) begin
            state_d = StRound;
          end
        end
      end
      StPad: begin
        if (blk_full) begin
          state_d = StRound;
        end
      end
      StRound: begin
        if (rnd_q == LastRound) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        // The length phase only ends on a full block, so it marks the end.
        if (pad_q) begin
          state_d = lenph_q ? StEmit : StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (emit_load && emit_idx_q == LastWord) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and datapath selects.
  always_comb begin
    q_pop_o   = (state_q == StIdle) && !q_empty_i;
    put_en    = (q_pop_o && !q_cmd_i.finish) || (state_q == StPad);
    emit_load = (state_q == StEmit) && (!out_valid_q || m_tready_i);

    case (off_q[2:0])
      3'd3:    len_byte = {5'b0, len_q[31:29]};
      3'd4:    len_byte = len_q[28:21];
      3'd5:    len_byte = len_q[20:13];
      3'd6:    len_byte = len_q[12:5];
      3'd7:    len_byte = {len_q[4:0], 3'b000};
      default: len_byte = 8'h00;
    endcase

    if (first_q) begin
      pad_val = PadByte;
    end else if (lenph_q || off_q == LenOffset) begin
      pad_val = len_byte;
    end else begin
      pad_val = 8'h00;
    end

    put_val  = (state_q == StIdle) ? q_cmd_i.data : pad_val;
    blk_full = put_en && (off_q == LastByte);

    if (rnd_q < 7'd20) begin
      f_k = (d_q ^ (b_q & (c_q ^ d_q))) + RoundK0;
    end else if (rnd_q < 7'd40) begin
      f_k = (b_q ^ c_q ^ d_q) + RoundK1;
    end else if (rnd_q < 7'd60) begin
      f_k = ((b_q & c_q) | (d_q & (b_q | c_q))) + RoundK2;
    end else begin
      f_k = (b_q ^ c_q ^ d_q) + RoundK3;
    end

    t_sum = f_k + {a_q[26:0], a_q[31:27]} + e_q + blk_q[0];
    // The window holds w[r..r+15]; this computes w[r+16].
    w_new = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // Block window and working variables carry no reset.
  always_ff @(posedge clk_i) begin
    if (put_en) begin
      blk_q[off_q[5:2]][{~off_q[1:0], 3'b000} +: 8] <= put_val;
    end else if (state_q == StRound) begin
      blk_q <= {w_new, blk_q[15:1]};
    end

    if (blk_full) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (state_q == StRound) begin
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end

    if (q_pop_o && q_cmd_i.finish) begin
      len_q  <= q_cmd_i.msg_len;
      wrap_q <= q_cmd_i.wrapped;
    end

    if (emit_load) begin
      out_word_q <= chain_q[emit_idx_q];
      out_idx_q  <= emit_idx_q;
      out_last_q <= (emit_idx_q == LastWord);
      out_ovf_q  <= wrap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chain_q     <= InitChain;
      off_q       <= '0;
      rnd_q       <= '0;
      pad_q       <= 1'b0;
      first_q     <= 1'b0;
      lenph_q     <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (put_en) begin
        off_q <= off_q + 6'd1;
      end

      if (blk_full) begin
        rnd_q <= '0;
      end else if (state_q == StRound) begin
        rnd_q <= rnd_q + 7'd1;
      end

      if (state_q == StUpdate) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end

      if (q_pop_o && q_cmd_i.finish) begin
        pad_q   <= 1'b1;
        first_q <= 1'b1;
        lenph_q <= 1'b0;
      end else if (state_q == StPad) begin
        first_q <= 1'b0;
        if (!first_q && off_q == LenOffset) begin
          lenph_q <= 1'b1;
        end
      end

      if (emit_load) begin
        out_valid_q <= 1'b1;
        if (emit_idx_q == LastWord) begin
          emit_idx_q <= '0;
          chain_q    <= InitChain;
          pad_q      <= 1'b0;
          lenph_q    <= 1'b0;
        end else begin
          emit_idx_q <= emit_idx_q + 3'd1;
        end
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_word_q;
  assign m_tuser_o  = {out_ovf_q, out_idx_q};
  assign m_tlast_o  = out_last_q;

endmodule

// ===== rtl/sha1_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// Append request: the engine stores the byte; the 64th byte of a block adds a
// compression (80 rounds, one per cycle in the round unit, then chain update).
// Finish request: 9 to 72 padding bytes, one byte per cycle, with one or two
// block compressions, then five digest words at one per cycle while the sink
// is ready. Requests wait in a short queue, so input flows until it is full.
// Reset loads the initial chain values, clears counts and empties the queue.
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 digest over a byte stream with a request queue and a round engine.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher
  import sha1_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [3:0]  m_axis_tuser,   // [2:0] word_index, [3] length_overflow
  output logic        m_axis_tlast    // last_word
);

  logic      q_push, q_full, q_pop, q_empty;
  sha1_cmd_t push_cmd, pop_cmd;

  sha1_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  sha1_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (pop_cmd),
    .empty_o (q_empty)
  );

  sha1_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_cmd_i    (pop_cmd),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  a_no_push_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full
  ) else $error("request pushed into a full queue");

  a_last_on_fifth : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:0] == LastWord))
  ) else $error("tlast does not match the final digest word");

  a_words_in_order : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser[2:0] == $past(m_axis_tuser[2:0]) + 3'd1)
  ) else $error("digest words not streamed back to back in order");

endmodule

// ===== test/sha1_byte_stream_hasher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_tb
// Drives byte and finish requests into the hasher and checks every digest
// word against a behavioral SHA-1 model kept in step with accepted requests.
// Known digests (empty string, "abc") are typed into the directed table;
// all other messages, including a full-block length, are predicted.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_tb;
  import sha1_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 200;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  word_idx;
    logic        last_flag;
    logic        ovf;
  } digest_beat_t;

  typedef struct {
    logic             req;
    logic [7:0]       data;
    bit               typed;
    logic [4:0][31:0] digest;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Model state of the hasher.
  logic [4:0][31:0]  chain_q;
  logic [15:0][31:0] block_q;
  logic [5:0]        fill_q;
  logic [31:0]       byte_count_q;
  logic              wrapped_q;

  digest_beat_t pending_words[$];
  stim_row_t    stim_table[$];

  int          error_count = 0;
  int          items_sent = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int unsigned cycle_count = 0;

  sha1_byte_stream_hasher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_block();
    logic [15:0][31:0] w;
    logic [31:0] a, b, c, d, e, f, t;
    int r;
    w = block_q;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        t = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
        w[r % 16] = rotl32(t, 1);
      end
      if (r < 20)      f = (d ^ (b & (c ^ d))) + RoundK0;
      else if (r < 40) f = (b ^ c ^ d) + RoundK1;
      else if (r < 60) f = ((b & c) | (d & (b | c))) + RoundK2;
      else             f = (b ^ c ^ d) + RoundK3;
      t = f + rotl32(a, 5) + e + w[r % 16];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain_q[0] = chain_q[0] + a;
    chain_q[1] = chain_q[1] + b;
    chain_q[2] = chain_q[2] + c;
    chain_q[3] = chain_q[3] + d;
    chain_q[4] = chain_q[4] + e;
  endtask

  // Bytes land big-endian in the block; a full block is compressed at once.
  task automatic place_byte(input logic [7:0] v);
    int sh;
    sh = (3 - fill_q[1:0]) * 8;
    block_q[fill_q[5:2]][sh +: 8] = v;
    if (fill_q == LastByte) begin
      compress_block();
      fill_q = '0;
    end else begin
      fill_q = fill_q + 6'd1;
    end
  endtask

  task automatic start_message();
    chain_q      = InitChain;
    fill_q       = '0;
    byte_count_q = '0;
    wrapped_q    = 1'b0;
  endtask

  task automatic absorb_request(input logic req, input logic [7:0] b,
                                output logic [4:0][31:0] digest, output logic ovf,
                                output bit emitted);
    logic [31:0] n;
    emitted = 1'b0;
    digest  = '0;
    ovf     = 1'b0;
    if (req == ReqAppend) begin
      byte_count_q = byte_count_q + 32'd1;
      if (byte_count_q == '0) wrapped_q = 1'b1;
      place_byte(b);
    end else begin
      n = byte_count_q;
      place_byte(PadByte);
      while (fill_q != LenOffset) place_byte(8'h00);
      place_byte(8'h00);
      place_byte(8'h00);
      place_byte(8'h00);
      place_byte(8'(n >> 29));
      place_byte(8'(n >> 21));
      place_byte(8'(n >> 13));
      place_byte(8'(n >> 5));
      place_byte(8'(n << 3));
      digest  = chain_q;
      ovf     = wrapped_q;
      emitted = 1'b1;
      start_message();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Within this task the valid line is only lowered inside the idle loop, so a
  // back-to-back request never sees two assignments to it in one step.
  task automatic send_request(input logic req, input logic [7:0] b, input bit typed,
                              input logic [4:0][31:0] typed_digest);
    logic [4:0][31:0] digest;
    logic ovf;
    bit emitted;
    digest_beat_t beat;
    int k;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    absorb_request(req, b, digest, ovf, emitted);
    if (emitted) begin
      for (k = 0; k < 5; k++) begin
        beat.word      = typed ? typed_digest[k] : digest[k];
        beat.word_idx  = 3'(k);
        beat.last_flag = (3'(k) == LastWord);
        beat.ovf       = ovf;
        pending_words.push_back(beat);
      end
    end
  endtask

  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) send_request(ReqAppend, 8'($urandom_range(0, 255)), 1'b0, '0);
    // The data byte of a finish request is noise that the block must ignore.
    send_request(ReqFinish, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic add_row(input logic req, input logic [7:0] data, input bit typed,
                         input logic [4:0][31:0] digest);
    stim_row_t row;
    row.req    = req;
    row.data   = data;
    row.typed  = typed;
    row.digest = digest;
    stim_table.push_back(row);
  endtask

  task automatic wait_all_words();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_digest_word();
    digest_beat_t want;
    if (pending_words.size() == 0) begin
      report_mismatch("unexpected digest word", m_axis_tdata, '0);
    end else begin
      want = pending_words.pop_front();
      if (m_axis_tdata !== want.word)
        report_mismatch("digest_word", m_axis_tdata, want.word);
      if (m_axis_tuser[2:0] !== want.word_idx)
        report_mismatch("word_index", 32'(m_axis_tuser[2:0]), 32'(want.word_idx));
      if (m_axis_tlast !== want.last_flag)
        report_mismatch("last_word", 32'(m_axis_tlast), 32'(want.last_flag));
      if (m_axis_tuser[3] !== want.ovf)
        report_mismatch("length_overflow", 32'(m_axis_tuser[3]), 32'(want.ovf));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_digest_word();
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sha1_byte_stream_hasher_tb NOT OK");
    $finish;
  end

  initial begin
    logic [4:0][31:0] empty_digest;
    logic [4:0][31:0] abc_digest;
    int i;
    int phase;
    int phase_start;
    int long_len;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ReqAppend;
    m_axis_tready = 1'b0;
    block_q       = '0;
    start_message();

    empty_digest = {32'hafd80709, 32'h95601890, 32'h3255bfef, 32'h5e6b4b0d, 32'hda39a3ee};
    abc_digest   = {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571, 32'h4706816a, 32'ha9993e36};

    // Empty message straight after reset, then again right after a finish.
    add_row(ReqFinish, 8'h00, 1'b1, empty_digest);
    add_row(ReqFinish, 8'hff, 1'b1, empty_digest);
    add_row(ReqAppend, 8'h61, 1'b0, '0);
    add_row(ReqAppend, 8'h62, 1'b0, '0);
    add_row(ReqAppend, 8'h63, 1'b0, '0);
    add_row(ReqFinish, 8'h5a, 1'b1, abc_digest);
    add_row(ReqAppend, 8'h00, 1'b0, '0);
    add_row(ReqFinish, 8'h00, 1'b0, '0);
    add_row(ReqAppend, 8'hff, 1'b0, '0);
    add_row(ReqFinish, 8'hff, 1'b0, '0);
    add_row(ReqAppend, 8'h00, 1'b0, '0);
    add_row(ReqAppend, 8'hff, 1'b0, '0);
    add_row(ReqAppend, 8'h55, 1'b0, '0);
    add_row(ReqAppend, 8'haa, 1'b0, '0);
    add_row(ReqAppend, 8'h80, 1'b0, '0);
    add_row(ReqFinish, 8'h01, 1'b0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 17;
    sink_idle_pct = 49;
    for (i = 0; i < stim_table.size(); i++) begin
      send_request(stim_table[i].req, stim_table[i].data, stim_table[i].typed,
                   stim_table[i].digest);
    end
    wait_all_words();

    // The first phase opens with a message that fills exactly one block.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 17;
          sink_idle_pct = 49;
          long_len      = 64;
        end
        1: begin
          src_idle_pct  = 49;
          sink_idle_pct = 17;
          long_len      = 7;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          long_len      = 3;
        end
      endcase
      phase_start = items_sent;
      send_message(long_len);
      while (items_sent - phase_start < 20) send_message($urandom_range(0, 9));
      wait_all_words();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sha1_byte_stream_hasher_tb OK");
    end else begin
      $display("sha1_byte_stream_hasher_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sha1_pkg.sv
rtl/sha1_front.sv
rtl/sha1_queue.sv
rtl/sha1_core.sv
rtl/sha1_byte_stream_hasher.sv
test/sha1_byte_stream_hasher_tb.sv
